// ----- rtl/sfm_pkg.sv -----
// shared types and constants for the streaming substring search
`default_nettype none

package sfm_pkg;

    // widest pattern the register map can describe
    localparam int PAT_BYTES = 16;

    typedef logic [7:0]                  byte_t;
    typedef logic [4:0]                  len_t;
    typedef logic [31:0]                 offset_t;
    typedef logic [PAT_BYTES-1:0][7:0]   pat_t;
    typedef logic [1:0]                  cfg_index_t;
    typedef logic [63:0]                 cfg_data_t;

    // configuration register indexes
    localparam cfg_index_t REG_PATTERN_LOW  = 2'd0;
    localparam cfg_index_t REG_PATTERN_HIGH = 2'd1;
    localparam cfg_index_t REG_PATTERN_LEN  = 2'd2;

    // result status codes
    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_MATCH_NOW = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/sfm_cell.sv -----
// one window cell: holds one past text byte, shifts it on, compares it to its pattern byte
`default_nettype none

module sfm_cell
    import sfm_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  shift,
    input  wire logic  clear,
    input  wire byte_t byte_in,
    input  wire pat_t  pattern,
    input  wire len_t  len,
    output byte_t      byte_out,
    output logic       ok
);

    // this cell holds the byte that lies IDX+1 places behind the current one
    localparam len_t BACK     = len_t'(IDX + 1);
    localparam len_t BACK_P1  = len_t'(IDX + 2);

    byte_t byte_reg;
    byte_t byte_next;
    len_t  sel;

    // window byte register
    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
        begin
            byte_next = '0;
        end
        else if (shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // pattern byte that must sit at this distance: index len-2-IDX
    always_comb
    begin
        sel = len - BACK_P1;
        ok  = (len <= BACK) || (byte_reg == pattern[sel[3:0]]);
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

// ----- rtl/substring_first_match.sv -----
// top level of the streaming first-match substring search
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall  text_byte, last_byte
//   out       output     out_valid/out_stall status, match_offset, end_of_text
//   cfg       input      cfg_we             cfg_index, cfg_data
//
// one text byte per cycle unless in_stall; each byte yields one registered result.
// the pattern compare runs in parallel over a row of window cells, one per past byte.
// a two-entry output stage (output register plus skid) keeps the input open while
// a result waits; in_stall rises only when both entries hold results.
// reset clears the window, counters, found flag and pattern registers at once.
`default_nettype none

module substring_first_match
    import sfm_pkg::*;
#(
    parameter int PATTERN_MAX = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // text input
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire byte_t      text_byte,
    input  wire logic       last_byte,
    // results
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      status,
    output offset_t         match_offset,
    output logic            end_of_text,
    // configuration
    input  wire logic       cfg_we,
    input  wire cfg_index_t cfg_index,
    input  wire cfg_data_t  cfg_data
);

    localparam len_t LEN_MAX = len_t'(PATTERN_MAX);

    // configuration registers
    cfg_data_t pattern_low_reg;
    cfg_data_t pattern_high_reg;
    len_t      pattern_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            pattern_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    pat_t  pattern;
    len_t  len_eff;
    len_t  len_m1;
    logic  in_fire;

    assign pattern = pat_t'({pattern_high_reg, pattern_low_reg});
    assign len_eff = (pattern_len_reg > LEN_MAX) ? LEN_MAX : pattern_len_reg;
    assign len_m1  = len_eff - len_t'(1);
    assign in_fire = in_valid && !in_stall;

    // row of window cells, cell k holds the byte k+1 places back
    byte_t                  chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_ok;

    assign chain[0]   = text_byte;
    assign cell_ok[0] = (len_eff == '0) || (text_byte == pattern[len_m1[3:0]]);

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX - 1; k++)
        begin : g_cell
            sfm_cell #(.IDX(k)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (in_fire && !last_byte),
                .clear    (in_fire && last_byte),
                .byte_in  (chain[k]),
                .pattern  (pattern),
                .len      (len_eff),
                .byte_out (chain[k+1]),
                .ok       (cell_ok[k+1])
            );
        end
    endgenerate

    // stream state
    offset_t bytes_seen_reg, bytes_seen_next;
    logic    found_reg, found_next;
    offset_t found_offset_reg, found_offset_next;
    status_t status_new;
    offset_t offset_new;
    logic    enough;
    offset_t start_off;

    assign enough    = bytes_seen_reg >= {27'd0, len_m1};
    assign start_off = bytes_seen_reg - {27'd0, len_m1};

    // result and next stream state for the byte at the input
    always_comb
    begin
        status_new        = ST_SEARCHING;
        offset_new        = '0;
        found_next        = found_reg;
        found_offset_next = found_offset_reg;
        bytes_seen_next   = bytes_seen_reg;

        priority if (found_reg)
        begin
            status_new = ST_FOUND;
            offset_new = found_offset_reg;
        end
        else if (len_eff == '0)
        begin
            status_new        = ST_MATCH_NOW;
            found_next        = 1'b1;
            found_offset_next = '0;
        end
        else if (enough && (&cell_ok))
        begin
            status_new        = ST_MATCH_NOW;
            offset_new        = start_off;
            found_next        = 1'b1;
            found_offset_next = start_off;
        end
        else
        begin
            status_new = ST_SEARCHING;
        end

        if (status_new == ST_SEARCHING && last_byte)
        begin
            status_new = ST_NOT_FOUND;
        end

        if (last_byte)
        begin
            bytes_seen_next   = '0;
            found_next        = 1'b0;
            found_offset_next = '0;
        end
        else if (bytes_seen_reg != '1)
        begin
            bytes_seen_next = bytes_seen_reg + offset_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg   <= '0;
            found_reg        <= 1'b0;
            found_offset_reg <= '0;
        end
        else if (in_fire)
        begin
            bytes_seen_reg   <= bytes_seen_next;
            found_reg        <= found_next;
            found_offset_reg <= found_offset_next;
        end
    end

    // output register and skid entry
    logic    out_valid_reg, skid_valid_reg;
    status_t out_status_reg, skid_status_reg;
    offset_t out_offset_reg, skid_offset_reg;
    logic    out_eot_reg, skid_eot_reg;
    logic    out_fire;

    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the two entries
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_status_reg <= skid_status_reg;
                out_offset_reg <= skid_offset_reg;
                out_eot_reg    <= skid_eot_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_status_reg <= status_new;
                skid_offset_reg <= offset_new;
                skid_eot_reg    <= last_byte;
            end
            else
            begin
                out_status_reg <= status_new;
                out_offset_reg <= offset_new;
                out_eot_reg    <= last_byte;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign match_offset = out_offset_reg;
    assign end_of_text  = out_eot_reg;

endmodule

`default_nettype wire
